[hw/rtl/tmtw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tmtw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  typedef logic [15:0] cell_t;

  // Operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Special characters
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Color reset values
  localparam logic [3:0] RESET_FG = 4'd2;
  localparam logic [3:0] RESET_BG = 4'd0;

  // Register index, taken from address bit 2
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  // Background in [15:12], foreground in [11:8], character in [7:0]
  function automatic cell_t make_cell(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
    return {bg, fg, ch};
  endfunction

  localparam cell_t RESET_CELL = {RESET_BG, RESET_FG, CH_SPACE};

endpackage

`default_nettype wire

[hw/rtl/text_mode_terminal_writer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Teletype writer for a ROWS x COLUMNS text screen held in one single-port-write,
// single-port-read cell memory, with the cursor kept in local registers. Every
// item gives exactly one result item. A read passes through a registered memory
// read before its result. A put that scrolls moves the rows up one cell per cycle
// through the memory's read and write ports, then blanks the bottom row one cell
// per cycle. A clear fills the screen one cell per cycle. After reset a clearing
// pass fills the screen with green-on-black spaces; no item is accepted during it,
// but configuration writes are. Registers: offset 0 is the foreground nibble,
// offset 4 the background nibble.
module text_mode_terminal_writer
  import tmtw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int ROW_W  = $clog2(ROWS),
  localparam int COL_W  = $clog2(COLUMNS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Input item
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       op,
  input  wire logic [7:0]       char_code,
  input  wire logic [3:0]       clear_color,
  input  wire logic [ROW_W-1:0] read_row,
  input  wire logic [COL_W-1:0] read_col,
  // Result item
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ROW_W-1:0]      cursor_row,
  output logic [COL_W-1:0]      cursor_col,
  output logic                  scrolled,
  output logic [15:0]           cell_value,
  // Configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BLANK_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);

  // Sequencer states
  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scr;
  } pos_t;

  function automatic pos_t advance_pos(pos_t p);
    pos_t n;
    n = p;
    if (p.col == LAST_COL) begin
      n.col = '0;
      if (p.row == LAST_ROW) begin
        n.scr = 1'b1;
      end else begin
        n.row = p.row + 1'b1;
      end
    end else begin
      n.col = p.col + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ROW_STRIDE + ADDR_W'(c));
  endfunction

  logic [2:0]        state;
  logic [3:0]        fg;
  logic [3:0]        bg;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] scan_idx;
  cell_t             fill_cell;
  logic              item_busy;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_waddr;
  logic              in_range;

  // Latched input item
  logic [1:0]        op_q;
  logic [7:0]        char_q;
  logic [3:0]        clr_q;
  logic [ROW_W-1:0]  rr_q;
  logic [COL_W-1:0]  rc_q;

  // Memory ports
  cell_t             cells [CELLS];
  cell_t             rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cell_t             mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  pos_t              put_pos;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= RESET_FG;
      bg <= RESET_BG;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_FG) begin
        fg <= pwdata[3:0];
      end else begin
        bg <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BG) begin
      prdata = {28'd0, bg};
    end else begin
      prdata = {28'd0, fg};
    end
  end

  // Cursor after a put
  always_comb begin
    pos_t p;
    p = '{row: cur_row, col: cur_col, scr: 1'b0};
    if (char_q == CH_NEWLINE) begin
      put_pos = p;
      put_pos.col = '0;
      if (cur_row == LAST_ROW) begin
        put_pos.scr = 1'b1;
      end else begin
        put_pos.row = cur_row + 1'b1;
      end
    end else if (char_q == CH_TAB) begin
      put_pos = advance_pos(advance_pos(p));
    end else begin
      put_pos = advance_pos(p);
    end
  end

  // Write port: pending copy, fill sweep, or a printed character
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(cur_row, cur_col);
    mem_wdata = make_cell(char_q, fg, bg);
    if (copy_pend) begin
      mem_we    = 1'b1;
      mem_waddr = copy_waddr;
      mem_wdata = rd_data;
    end else if (state == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = scan_idx;
      mem_wdata = fill_cell;
    end else if (state == S_EXEC && op_q == OP_PUT &&
                 char_q != CH_NEWLINE && char_q != CH_TAB) begin
      mem_we = 1'b1;
    end
  end

  // Read port: row below during a scroll, else the requested cell
  assign mem_raddr = (state == S_COPY) ? ADDR_W'(scan_idx + ROW_STRIDE)
                                       : cell_addr(rr_q, rc_q);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= cells[mem_raddr];
  end

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // Input item capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op;
      char_q <= char_code;
      clr_q  <= clear_color;
      rr_q   <= read_row;
      rc_q   <= read_col;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      scan_idx   <= '0;
      fill_cell  <= RESET_CELL;
      item_busy  <= 1'b0;
      copy_pend  <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      out_valid  <= 1'b0;
    end else begin
      copy_pend <= (state == S_COPY);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            OP_PUT: begin
              cur_row    <= put_pos.row;
              cur_col    <= put_pos.col;
              cursor_row <= put_pos.row;
              cursor_col <= put_pos.col;
              scrolled   <= put_pos.scr;
              cell_value <= '0;
              if (put_pos.scr) begin
                scan_idx  <= '0;
                item_busy <= 1'b1;
                state     <= S_COPY;
              end else begin
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end
            OP_READ: begin
              cursor_row <= cur_row;
              cursor_col <= cur_col;
              scrolled   <= 1'b0;
              in_range   <= (32'(rr_q) < ROWS) && (32'(rc_q) < COLUMNS);
              state      <= S_READ;
            end
            OP_CLEAR: begin
              cur_row    <= '0;
              cur_col    <= '0;
              cursor_row <= '0;
              cursor_col <= '0;
              scrolled   <= 1'b0;
              cell_value <= '0;
              fill_cell  <= make_cell(CH_SPACE, fg, clr_q);
              scan_idx   <= '0;
              item_busy  <= 1'b1;
              state      <= S_FILL;
            end
            default: begin
              cursor_row <= cur_row;
              cursor_col <= cur_col;
              scrolled   <= 1'b0;
              cell_value <= '0;
              out_valid  <= 1'b1;
              state      <= S_IDLE;
            end
          endcase
        end
        S_READ: begin
          cell_value <= in_range ? rd_data : '0;
          out_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        S_COPY: begin
          copy_waddr <= scan_idx;
          if (scan_idx == COPY_LAST) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          // last moved cell is written this cycle
          fill_cell <= make_cell(CH_SPACE, fg, bg);
          scan_idx  <= BLANK_FIRST;
          state     <= S_FILL;
        end
        S_FILL: begin
          if (scan_idx == LAST_CELL) begin
            if (item_busy) begin
              out_valid <= 1'b1;
            end
            item_busy <= 1'b0;
            state     <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Cursor always lands on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < ROWS) && (32'(cur_col) < COLUMNS))
    else $error("cursor left the screen");

  // A scroll always leaves the cursor on the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_row == LAST_ROW))
    else $error("scroll reported off the bottom row");

  // No new item while a moved cell is still to be written
  a_no_accept_copy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !copy_pend)
    else $error("item accepted during row move");

  // A result only comes from finishing work
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EXEC || $past(state) == S_READ ||
                          $past(state) == S_FILL))
    else $error("result item without finished work");
`endif

endmodule

`default_nettype wire

[bench/text_mode_terminal_writer_test.sv]
`timescale 1ns / 1ps

module text_mode_terminal_writer_test;
  import tmtw_pkg::*;

  localparam int NCOLS = DEF_COLUMNS;
  localparam int NROWS = DEF_ROWS;

  // Op code that the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [3:0] clr;
    logic [4:0] rr;
    logic [6:0] rc;
  } term_cmd_t;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
    logic [15:0] cell_val;
  } term_status_t;

  // Shadow screen, cursor and colors; one expected status per accepted command
  class screen_scoreboard;
    cell_t        screen [NROWS*NCOLS];
    int           row;
    int           col;
    logic [3:0]   fg;
    logic [3:0]   bg;
    term_status_t expected_status [$];
    int           mismatches;

    function new();
      foreach (screen[i]) screen[i] = {RESET_BG, RESET_FG, CH_SPACE};
      row = 0;
      col = 0;
      fg = RESET_FG;
      bg = RESET_BG;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Move every row up one, blank the bottom row in the current colors
    function void scroll_up();
      for (int i = 0; i < (NROWS-1)*NCOLS; i++) screen[i] = screen[i+NCOLS];
      for (int i = 0; i < NCOLS; i++) screen[(NROWS-1)*NCOLS + i] = {bg, fg, CH_SPACE};
    endfunction

    // Fix up the cursor after a move; returns 1 if the screen scrolled
    function bit settle_cursor();
      bit sc;
      sc = 0;
      if (row >= NROWS) begin
        scroll_up();
        row = NROWS - 1;
        sc = 1;
      end
      if (col >= NCOLS) begin
        col = 0;
        row++;
        if (row >= NROWS) begin
          scroll_up();
          row = NROWS - 1;
          sc = 1;
        end
      end
      return sc;
    endfunction

    // Apply one accepted command and queue the status it should produce
    function void accept_command(term_cmd_t c);
      term_status_t st;
      bit sc;
      st = '0;
      sc = 0;
      case (c.op)
        OP_PUT: begin
          if (c.ch == CH_NEWLINE) begin
            row++;
            col = 0;
            sc = settle_cursor();
          end else if (c.ch == CH_TAB) begin
            // two steps, each with its own wrap check
            col++;
            sc = settle_cursor();
            col++;
            if (settle_cursor()) sc = 1;
          end else begin
            screen[row*NCOLS + col] = {bg, fg, c.ch};
            col++;
            sc = settle_cursor();
          end
        end
        OP_READ: begin
          if (int'(c.rr) < NROWS && int'(c.rc) < NCOLS)
            st.cell_val = screen[int'(c.rr)*NCOLS + int'(c.rc)];
        end
        OP_CLEAR: begin
          foreach (screen[i]) screen[i] = {c.clr, fg, CH_SPACE};
          row = 0;
          col = 0;
        end
        default: ;
      endcase
      st.row = 5'(row);
      st.col = 7'(col);
      st.scrolled = sc;
      expected_status.push_back(st);
    endfunction

    function void check_reply(term_status_t got);
      term_status_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("result with nothing outstanding: row %0d col %0d",
                         got.row, got.col));
        return;
      end
      want = expected_status.pop_front();
      if (got.row != want.row)
        report($sformatf("cursor_row %0d, want %0d", got.row, want.row));
      if (got.col != want.col)
        report($sformatf("cursor_col %0d, want %0d", got.col, want.col));
      if (got.scrolled != want.scrolled)
        report($sformatf("scrolled %0b, want %0b", got.scrolled, want.scrolled));
      if (got.cell_val != want.cell_val)
        report($sformatf("cell_value %h, want %h", got.cell_val, want.cell_val));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_PUT;
  logic [7:0]  char_code = '0;
  logic [3:0]  clear_color = '0;
  logic [4:0]  read_row = '0;
  logic [6:0]  read_col = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic        scrolled;
  logic [15:0] cell_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  screen_scoreboard sb;
  bit calm = 1'b0;

  text_mode_terminal_writer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .char_code(char_code), .clear_color(clear_color),
    .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_row(cursor_row), .cursor_col(cursor_col),
    .scrolled(scrolled), .cell_value(cell_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random idling, off during the calm stretch
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 21);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= !idle_now();
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.accept_command({op, char_code, clear_color, read_row, read_col});
      if (out_valid && out_ready)
        sb.check_reply({cursor_row, cursor_col, scrolled, cell_value});
    end
  end

  task automatic send_item(logic [1:0] o, logic [7:0] ch, logic [3:0] clr,
                           logic [4:0] rr, logic [6:0] rc);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    char_code   <= ch;
    clear_color <= clr;
    read_row    <= rr;
    read_col    <= rc;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lets the last accepted item reach the queue before waiting for it to empty
  task automatic wait_drained();
    @(posedge clk);
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one color register, then read it back
  task automatic write_reg(logic idx, logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FG) sb.fg = v;
    else sb.bg = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[3:0] != v)
      sb.report($sformatf("register at %0d reads %h, want %h", {idx, 2'b00}, prdata, v));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly printing with newlines and tabs; reads on and off screen; some unused ops; rare clears
  task automatic send_random();
    logic [1:0] o;
    logic [7:0] ch;
    logic [3:0] clr;
    logic [4:0] rr;
    logic [6:0] rc;
    int pick;
    o   = OP_PUT;
    ch  = 8'($urandom);
    clr = 4'($urandom);
    rr  = 5'($urandom);
    rc  = 7'($urandom);
    pick = $urandom_range(0, 999);
    if (pick < 4) begin
      o = OP_CLEAR;
    end else if (pick < 24) begin
      o = OP_UNUSED;
    end else if (pick < 244) begin
      o = OP_READ;
      case ($urandom_range(0, 3))
        0: ; // any address, often off screen
        1: begin
          rr = 5'(sb.row);
          rc = (sb.col == 0) ? 7'd0 : 7'(sb.col - 1);
        end
        default: begin
          rr = 5'($urandom_range(0, NROWS-1));
          rc = 7'($urandom_range(0, NCOLS-1));
        end
      endcase
    end else if (pick < 394) begin
      ch = CH_NEWLINE;
    end else if (pick < 474) begin
      ch = CH_TAB;
    end
    send_item(o, ch, clr, rr, rc);
  endtask

  initial begin
    logic [3:0] fg_val;
    logic [3:0] bg_val;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset screen, reads off screen, extreme bytes, tab, newline, an unused op, clears
    send_item(OP_READ, 8'd0, 4'd0, 5'd0, 7'd0);
    send_item(OP_READ, 8'hff, 4'hf, 5'd24, 7'd79);
    send_item(OP_READ, 8'd0, 4'd0, 5'd25, 7'd0);
    send_item(OP_READ, 8'd0, 4'd0, 5'd0, 7'd80);
    send_item(OP_READ, 8'hff, 4'hf, 5'd31, 7'd127);
    send_item(OP_PUT, 8'h41, 4'd0, 5'd0, 7'd0);
    send_item(OP_PUT, 8'h00, 4'd0, 5'd0, 7'd0);
    send_item(OP_PUT, 8'hff, 4'hf, 5'd31, 7'd127);
    send_item(OP_PUT, CH_TAB, 4'd0, 5'd0, 7'd0);
    send_item(OP_PUT, CH_NEWLINE, 4'd0, 5'd0, 7'd0);
    send_item(OP_PUT, CH_SPACE, 4'd0, 5'd0, 7'd0);
    send_item(OP_UNUSED, 8'h41, 4'hf, 5'd0, 7'd0);
    send_item(OP_READ, 8'd0, 4'd0, 5'd0, 7'd0);
    send_item(OP_READ, 8'd0, 4'd0, 5'd0, 7'd1);
    send_item(OP_READ, 8'd0, 4'd0, 5'd0, 7'd2);
    send_item(OP_READ, 8'd0, 4'd0, 5'd1, 7'd0);
    send_item(OP_CLEAR, 8'd0, 4'hf, 5'd0, 7'd0);
    send_item(OP_READ, 8'd0, 4'd0, 5'd12, 7'd40);
    send_item(OP_PUT, 8'h7e, 4'd0, 5'd0, 7'd0);
    send_item(OP_CLEAR, 8'd0, 4'd0, 5'd0, 7'd0);
    send_item(OP_READ, 8'd0, 4'd0, 5'd0, 7'd0);
    in_valid <= 1'b0;

    // Random phases, each under its own colors
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: begin fg_val = 4'hf; bg_val = 4'h0; end
        1: begin fg_val = 4'h0; bg_val = 4'hf; end
        2: begin fg_val = 4'h0; bg_val = 4'h0; end
        3: begin fg_val = 4'hf; bg_val = 4'hf; end
        default: begin fg_val = 4'($urandom); bg_val = 4'($urandom); end
      endcase
      write_reg(REG_FG, fg_val);
      write_reg(REG_BG, bg_val);
      calm = (ph == 4);
      if (ph == 3 || ph == 6)
        send_item(OP_CLEAR, 8'd0, 4'($urandom), 5'd0, 7'd0);
      repeat (212) send_random();
      in_valid <= 1'b0;
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_status.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("timeout, %0d results outstanding", sb.expected_status.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
